### src/periodic_two_way_slot_allocator_unit_macros.svh
// Assertion helpers shared by the allocator RTL.
// Each macro expects clk and rst_n in scope.
`ifndef PERIODIC_TWO_WAY_SLOT_ALLOCATOR_UNIT_MACROS_SVH
`define PERIODIC_TWO_WAY_SLOT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define PTWSA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PTWSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ptwsa_pkg.sv
package ptwsa_pkg;

  localparam int CFG_W    = 11;
  localparam int OFFSET_W = 12;
  localparam int RAND_W   = 31;
  localparam int SLOT_W   = 10;
  localparam int COUNT_W  = 11;

  localparam logic [CFG_W-1:0] PERIOD_RESET = 11'd1000;
  localparam logic [CFG_W-1:0] LIMIT_RESET  = 11'd600;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_PERIOD       = 1'b0;
  localparam cfg_idx_t CFG_SEARCH_LIMIT = 1'b1;

  localparam logic KIND_PLACE = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [OFFSET_W-1:0] offset;
    logic [RAND_W-1:0]   rand_value;
  } in_item_t;

  typedef struct packed {
    logic               placed;
    logic [SLOT_W-1:0]  forward_slot;
    logic [SLOT_W-1:0]  return_slot;
    logic [COUNT_W-1:0] usable_count;
    logic [COUNT_W-1:0] placed_total;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD_SHIFT,
    ST_COUNT,
    ST_MOD_PICK,
    ST_FIND,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

### src/ptwsa_ifs.sv
interface ptwsa_in_if;
  logic                valid;
  logic                ready;
  ptwsa_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptwsa_out_if;
  logic                 valid;
  logic                 ready;
  ptwsa_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/periodic_two_way_slot_allocator_unit.sv
// Periodic two-way slot allocator.
// Input channel in_ch (valid/ready) carries one transaction per route: kind,
// offset and rand_value. Output channel out_ch returns exactly one result
// transaction per input transaction. cfg_we/cfg_index/cfg_wdata write the
// period and search_limit registers; write them only while the block is idle.
// Both occupancy maps live in two single-bit RAMs of PERIOD_MAX entries with
// a registered read; every scan step reads one forward and one return entry.
// A place transaction, with L the clamped search limit, steps through accept,
// offset mod period, a count pass over L window slots, rand mod count, a pick
// pass, a map write and the result; with no usable slot the pick pass and map
// write are skipped. A clear transaction sweeps both RAMs, one entry per
// cycle. One transaction is in flight at a time.
// Reset: the block runs the same clearing pass over all PERIOD_MAX entries,
// holding in_ch.ready low, and loads period 1000 and search limit 600.
// Stall: the result sits in an output register; the block accepts the next
// transaction while it waits, and holds the following result until out_ch
// drains.
`include "periodic_two_way_slot_allocator_unit_macros.svh"

module periodic_two_way_slot_allocator_unit #(
  parameter int PERIOD_MAX = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ptwsa_in_if.sink                      in_ch,
  ptwsa_out_if.source                   out_ch,
  input  logic                          cfg_we,
  input  ptwsa_pkg::cfg_idx_t           cfg_index,
  input  logic [ptwsa_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(PERIOD_MAX);
  localparam int CW = $clog2(PERIOD_MAX + 1);
  // working width for slot indexes, counts and the period
  localparam int SW = (CW > ptwsa_pkg::CFG_W) ? CW : ptwsa_pkg::CFG_W;
  localparam logic [AW-1:0] LAST_ENTRY = AW'(PERIOD_MAX - 1);

  ptwsa_pkg::state_t state_r, state_nxt;

  logic [ptwsa_pkg::CFG_W-1:0] period_r, limit_cfg_r;

  logic [SW-1:0] p_r, p_nxt, lim_r, lim_nxt;
  logic [SW-1:0] shift_r, shift_nxt;
  logic [ptwsa_pkg::RAND_W-1:0] rand_r, rand_nxt;
  logic [SW-1:0] s_r, s_nxt, r_r, r_nxt;
  logic          rd_v_r, rd_v_nxt;
  logic [SW-1:0] rd_s_r, rd_s_nxt, rd_r_r, rd_r_nxt;
  logic [SW-1:0] count_r, count_nxt, pick_r, pick_nxt;
  logic [SW-1:0] fwd_r, fwd_nxt, ret_r, ret_nxt;
  logic          placed_r, placed_nxt;
  logic [ptwsa_pkg::COUNT_W-1:0] total_r, total_nxt;
  logic [AW-1:0] clr_idx_r, clr_idx_nxt;
  logic          clr_res_r, clr_res_nxt;
  logic          out_valid_r, out_valid_nxt;
  ptwsa_pkg::out_item_t out_data_r, out_data_nxt;

  logic [SW-1:0] p_eff, lim_eff, limit_ext, r_inc, r_wrap;
  logic          issue, usable;
  logic          f_q, r_q;
  logic          we;
  logic [AW-1:0] f_waddr, r_waddr;
  logic          wbit;
  logic          mod_start, mod_done;
  logic [ptwsa_pkg::RAND_W-1:0] mod_dividend;
  logic [SW-1:0] mod_divisor, mod_rem;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= ptwsa_pkg::PERIOD_RESET;
      limit_cfg_r <= ptwsa_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ptwsa_pkg::CFG_PERIOD:       period_r    <= cfg_wdata;
        ptwsa_pkg::CFG_SEARCH_LIMIT: limit_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective period: zero reads as one, saturate at PERIOD_MAX.
  // Clamp the search window to it.
  always_comb begin
    p_eff = SW'(period_r);
    if (period_r == '0) begin
      p_eff = SW'(1);
    end
    if (p_eff > SW'(PERIOD_MAX)) begin
      p_eff = SW'(PERIOD_MAX);
    end
    limit_ext = SW'(limit_cfg_r);
    lim_eff   = (limit_ext > p_eff) ? p_eff : limit_ext;
  end

  // Scan address generation; the return index walks with wrap at the period.
  assign issue  = ((state_r == ptwsa_pkg::ST_COUNT) || (state_r == ptwsa_pkg::ST_FIND)) &&
                  (s_r < lim_r);
  assign r_inc  = r_r + SW'(1);
  assign r_wrap = (r_inc == p_r) ? '0 : r_inc;
  assign usable = rd_v_r && !f_q && !r_q;

  ptwsa_ram #(.WIDTH(1), .DEPTH(PERIOD_MAX)) u_fwd_map (
    .clk   (clk),
    .we    (we),
    .waddr (f_waddr),
    .wdata (wbit),
    .raddr (s_r[AW-1:0]),
    .rdata (f_q)
  );

  ptwsa_ram #(.WIDTH(1), .DEPTH(PERIOD_MAX)) u_ret_map (
    .clk   (clk),
    .we    (we),
    .waddr (r_waddr),
    .wdata (wbit),
    .raddr (r_r[AW-1:0]),
    .rdata (r_q)
  );

  // Shared remainder unit: offset mod period, then rand mod usable count.
  ptwsa_mod #(.DIVIDEND_W(ptwsa_pkg::RAND_W), .DIVISOR_W(SW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    if (state_r == ptwsa_pkg::ST_IDLE) begin
      mod_dividend = {{(ptwsa_pkg::RAND_W - ptwsa_pkg::OFFSET_W){1'b0}}, in_ch.data.offset};
      mod_divisor  = p_eff;
    end else begin
      mod_dividend = rand_r;
      mod_divisor  = count_r;
    end
  end

  assign in_ch.ready  = (state_r == ptwsa_pkg::ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // Next state and datapath control.
  always_comb begin
    state_nxt     = state_r;
    p_nxt         = p_r;
    lim_nxt       = lim_r;
    shift_nxt     = shift_r;
    rand_nxt      = rand_r;
    s_nxt         = s_r;
    r_nxt         = r_r;
    rd_v_nxt      = issue;
    rd_s_nxt      = s_r;
    rd_r_nxt      = r_r;
    count_nxt     = count_r;
    pick_nxt      = pick_r;
    fwd_nxt       = fwd_r;
    ret_nxt       = ret_r;
    placed_nxt    = placed_r;
    total_nxt     = total_r;
    clr_idx_nxt   = clr_idx_r;
    clr_res_nxt   = clr_res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    mod_start     = 1'b0;
    we            = 1'b0;
    f_waddr       = clr_idx_r;
    r_waddr       = clr_idx_r;
    wbit          = 1'b0;

    if (issue) begin
      s_nxt = s_r + SW'(1);
      r_nxt = r_wrap;
    end

    case (state_r)
      ptwsa_pkg::ST_CLEAR: begin
        // sweep one entry of each map per cycle
        we          = 1'b1;
        clr_idx_nxt = (clr_idx_r == LAST_ENTRY) ? '0 : clr_idx_r + AW'(1);
        if (clr_idx_r == LAST_ENTRY) begin
          state_nxt = clr_res_r ? ptwsa_pkg::ST_DONE : ptwsa_pkg::ST_IDLE;
        end
      end
      ptwsa_pkg::ST_IDLE: begin
        if (in_ch.valid) begin
          rand_nxt   = in_ch.data.rand_value;
          p_nxt      = p_eff;
          lim_nxt    = lim_eff;
          fwd_nxt    = '0;
          ret_nxt    = '0;
          count_nxt  = '0;
          placed_nxt = 1'b0;
          if (in_ch.data.kind == ptwsa_pkg::KIND_CLEAR) begin
            clr_idx_nxt = '0;
            clr_res_nxt = 1'b1;
            total_nxt   = '0;
            state_nxt   = ptwsa_pkg::ST_CLEAR;
          end else begin
            mod_start = 1'b1;
            state_nxt = ptwsa_pkg::ST_MOD_SHIFT;
          end
        end
      end
      ptwsa_pkg::ST_MOD_SHIFT: begin
        if (mod_done) begin
          shift_nxt = mod_rem;
          s_nxt     = '0;
          r_nxt     = mod_rem;
          state_nxt = ptwsa_pkg::ST_COUNT;
        end
      end
      ptwsa_pkg::ST_COUNT: begin
        if (usable) begin
          count_nxt = count_r + SW'(1);
        end
        // pass ends once the last read has come back
        if (!issue && !rd_v_r) begin
          if (count_r == '0) begin
            state_nxt = ptwsa_pkg::ST_DONE;
          end else begin
            mod_start = 1'b1;
            state_nxt = ptwsa_pkg::ST_MOD_PICK;
          end
        end
      end
      ptwsa_pkg::ST_MOD_PICK: begin
        if (mod_done) begin
          pick_nxt  = mod_rem;
          s_nxt     = '0;
          r_nxt     = shift_r;
          state_nxt = ptwsa_pkg::ST_FIND;
        end
      end
      ptwsa_pkg::ST_FIND: begin
        if (usable) begin
          if (pick_r == '0) begin
            fwd_nxt   = rd_s_r;
            ret_nxt   = rd_r_r;
            state_nxt = ptwsa_pkg::ST_WRITE;
          end else begin
            pick_nxt = pick_r - SW'(1);
          end
        end
      end
      ptwsa_pkg::ST_WRITE: begin
        // mark both slots busy; any read still in flight is ignored, so no forwarding needed
        we         = 1'b1;
        f_waddr    = fwd_r[AW-1:0];
        r_waddr    = ret_r[AW-1:0];
        wbit       = 1'b1;
        placed_nxt = 1'b1;
        if (total_r != '1) begin
          total_nxt = total_r + ptwsa_pkg::COUNT_W'(1);
        end
        state_nxt = ptwsa_pkg::ST_DONE;
      end
      ptwsa_pkg::ST_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.placed       = placed_r;
          out_data_nxt.forward_slot = fwd_r[ptwsa_pkg::SLOT_W-1:0];
          out_data_nxt.return_slot  = ret_r[ptwsa_pkg::SLOT_W-1:0];
          out_data_nxt.usable_count = count_r[ptwsa_pkg::COUNT_W-1:0];
          out_data_nxt.placed_total = total_r;
          state_nxt                 = ptwsa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ptwsa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptwsa_pkg::ST_CLEAR;
    end else begin
      state_r     <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r      <= 1'b0;
      total_r     <= '0;
      clr_idx_r   <= '0;
      clr_res_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_v_r      <= rd_v_nxt;
      total_r     <= total_nxt;
      clr_idx_r   <= clr_idx_nxt;
      clr_res_r   <= clr_res_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    lim_r      <= lim_nxt;
    shift_r    <= shift_nxt;
    rand_r     <= rand_nxt;
    s_r        <= s_nxt;
    r_r        <= r_nxt;
    rd_s_r     <= rd_s_nxt;
    rd_r_r     <= rd_r_nxt;
    count_r    <= count_nxt;
    pick_r     <= pick_nxt;
    fwd_r      <= fwd_nxt;
    ret_r      <= ret_nxt;
    placed_r   <= placed_nxt;
    out_data_r <= out_data_nxt;
  end

  `PTWSA_ASSERT_SAME(a_fwd_in_window, (state_r == ptwsa_pkg::ST_WRITE), (fwd_r < lim_r),
                     "forward slot outside search window")
  `PTWSA_ASSERT_SAME(a_ret_in_frame, (state_r == ptwsa_pkg::ST_WRITE), (ret_r < p_r),
                     "return slot outside frame")
  `PTWSA_ASSERT_SAME(a_find_needs_count, (state_r == ptwsa_pkg::ST_FIND), (count_r != '0),
                     "pick pass without usable slots")
  `PTWSA_ASSERT_SAME(a_find_hits, (state_r == ptwsa_pkg::ST_FIND),
                     !((s_r == lim_r) && !rd_v_r), "pick pass ran off the window")
  `PTWSA_ASSERT_SAME(a_result_from_done, $rose(out_valid_r),
                     $past(state_r == ptwsa_pkg::ST_DONE), "result loaded outside done state")
  `PTWSA_ASSERT_NEXT(a_total_counts, (state_r == ptwsa_pkg::ST_WRITE), (total_r != '0),
                     "placement left counter at zero")

endmodule

### src/ptwsa_ram.sv
module ptwsa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/ptwsa_mod.sv
// Restoring remainder unit: one dividend bit per cycle.
module ptwsa_mod #(
  parameter int DIVIDEND_W = 31,
  parameter int DIVISOR_W  = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVISOR_W-1:0]  rem
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [DIVIDEND_W-1:0] q_r;
  logic [DIVISOR_W-1:0]  d_r;
  logic [DIVISOR_W-1:0]  rem_r;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic [DIVISOR_W-1:0]  rem_nxt;

  always_comb begin
    trial   = {rem_r, q_r[DIVIDEND_W-1]};
    diff    = trial - {1'b0, d_r};
    rem_nxt = (trial >= {1'b0, d_r}) ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[DIVIDEND_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule
